/* rtl/wrpm_pkg.sv */
// Shared types and constants for the windowed RMS and peak level meter.
// Holds the sample and result transaction structs and the register map.
// No dependencies.
`default_nettype none

package wrpm_pkg;

  // Sample width in bits, signed Q1.23
  localparam int SAMPLE_BITS = 24;
  localparam int INDEX_BITS = 32;

  // Register map: one 32-bit register, byte address 4*index
  localparam int ADDR_BITS = 3;
  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
  localparam int WINDOW_LENGTH_RESET = 2205;
  localparam int CFG_FIELD_BITS = 16;

  // One stereo sample pair
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } sample_t;

  // One window result
  typedef struct packed {
    logic [INDEX_BITS-1:0]  window_end_index;
    logic [SAMPLE_BITS-1:0] rms_left;
    logic [SAMPLE_BITS-1:0] rms_right;
    logic [SAMPLE_BITS-1:0] peak_left;
    logic [SAMPLE_BITS-1:0] peak_right;
  } result_t;

endpackage

`default_nettype wire

/* rtl/wrpm_sub.sv */
// Shared compare-and-subtract unit used by the divider and square root steps.
// Gives a - b and whether a >= b. Depends on nothing.
`default_nettype none

module wrpm_sub #(
  parameter int WIDTH = 35
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic      [WIDTH-1:0] diff,
  output logic                  ge
);

  logic [WIDTH:0] wide;

  // one subtract with borrow out
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[WIDTH-1:0];
  assign ge   = ~wide[WIDTH];

endmodule

`default_nettype wire

/* rtl/wrpm_core.sv */
// Sequencer and datapath of the level meter: squaring, accumulation, peaks,
// and the bit-serial divide and square root at each window close.
// Depends on wrpm_pkg and wrpm_sub.
`default_nettype none

module wrpm_core #(
  parameter int WINDOW_BITS = 16,
  parameter int CFG_W = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [CFG_W-1:0]     win_len,
  input  wire logic                 sample_valid,
  output logic                      sample_ready,
  input  wire wrpm_pkg::sample_t    sample,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output wrpm_pkg::result_t         result
);

  localparam int S       = wrpm_pkg::SAMPLE_BITS;
  localparam int W       = WINDOW_BITS;
  localparam int SUM_RAW = 2 * S - 1 + W;
  localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
  localparam int SQW     = SUM_W + (SUM_W % 2);
  localparam int ROOT_W  = SQW / 2;
  localparam int RW      = ((W + 1) > (ROOT_W + 1)) ? (W + 1) : (ROOT_W + 1);
  localparam int UW      = RW + 2;
  localparam int STEP_W  = $clog2(SQW);
  localparam int IDX_W   = wrpm_pkg::INDEX_BITS;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQL  = 4'd1;
  localparam logic [3:0] ST_SQR  = 4'd2;
  localparam logic [3:0] ST_ACR  = 4'd3;
  localparam logic [3:0] ST_DLD  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_SLD  = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0]        state;
  logic              ch;
  logic [STEP_W-1:0] step;

  // accumulated window state
  logic [SUM_W-1:0]  acc_l, acc_r;
  logic [S-1:0]      peak_l, peak_r;
  logic [W-1:0]      cnt;
  logic [IDX_W-1:0]  seen;

  // working registers
  logic [S-1:0]      mag_l, mag_r;
  logic [2*S-1:0]    prod;
  logic [SQW-1:0]    num;
  logic [RW-1:0]     rem;
  logic [ROOT_W-1:0] root;
  logic [S-1:0]      rms_l, rms_r;

  logic              accept;
  logic              load_out;
  logic              close;
  logic [S-1:0]      in_mag_l, in_mag_r;
  logic [S-1:0]      mul_a;
  logic [2*S-1:0]    mul_ext;
  logic [SUM_W:0]    sum;
  logic [SUM_W-1:0]  sum_sat;
  logic [W-1:0]      limit;
  logic [W:0]        divisor;
  logic [UW-1:0]     op_a, op_b, op_diff;
  logic              op_ge;
  logic [ROOT_W-1:0] root_next;

  assign sample_ready = (state == ST_IDLE) & ~rst;
  assign accept       = sample_valid & sample_ready;
  assign load_out     = (state == ST_DONE) & (~result_valid | result_ready);

  // magnitude of a two's complement sample; most negative code maps to 2^(S-1)
  assign in_mag_l = sample.left_sample[S-1]  ? (~sample.left_sample + 1'b1)
                                             : sample.left_sample;
  assign in_mag_r = sample.right_sample[S-1] ? (~sample.right_sample + 1'b1)
                                             : sample.right_sample;

  // shared squarer and saturating accumulator adder
  assign mul_a   = (state == ST_SQL) ? mag_l : mag_r;
  assign mul_ext = {{S{1'b0}}, mul_a};
  assign sum     = {1'b0, ((state == ST_SQR) ? acc_l : acc_r)}
                 + {{(SUM_W + 1 - 2 * S){1'b0}}, prod};
  assign sum_sat = sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];

  // window close test; a zero length acts as one, a wrapped count closes
  assign limit   = (win_len == '0) ? W'(1) : {{(W - CFG_W){1'b0}}, win_len};
  assign close   = (cnt == '0) || (cnt >= limit);
  assign divisor = (cnt == '0) ? {1'b1, {W{1'b0}}} : {1'b0, cnt};

  // operand select for the shared subtract unit
  always_comb begin
    if (state == ST_SQRT) begin
      op_a = {rem, num[SQW-1:SQW-2]};
      op_b = {{(RW - ROOT_W){1'b0}}, root, 2'b01};
    end else begin
      op_a = {1'b0, rem, num[SQW-1]};
      op_b = {{(UW - W - 1){1'b0}}, divisor};
    end
  end

  wrpm_sub #(.WIDTH(UW)) u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (op_diff),
    .ge   (op_ge)
  );

  assign root_next = {root[ROOT_W-2:0], op_ge};

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ch           <= 1'b0;
      step         <= '0;
      acc_l        <= '0;
      acc_r        <= '0;
      peak_l       <= '0;
      peak_r       <= '0;
      cnt          <= '0;
      seen         <= '0;
      result_valid <= 1'b0;
    end else begin
      // output register: loaded at window close, cleared once taken
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_mag_l > peak_l) begin
              peak_l <= in_mag_l;
            end
            if (in_mag_r > peak_r) begin
              peak_r <= in_mag_r;
            end
            cnt   <= cnt + 1'b1;
            seen  <= seen + 1'b1;
            state <= ST_SQL;
          end
        end
        ST_SQL: begin
          state <= ST_SQR;
        end
        ST_SQR: begin
          acc_l <= sum_sat;
          state <= ST_ACR;
        end
        ST_ACR: begin
          acc_r <= sum_sat;
          ch    <= 1'b0;
          state <= close ? ST_DLD : ST_IDLE;
        end
        ST_DLD: begin
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(SQW - 1)) begin
            state <= ST_SLD;
          end
        end
        ST_SLD: begin
          step  <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          step <= step + 1'b1;
          if (step == STEP_W'(ROOT_W - 1)) begin
            ch    <= 1'b1;
            state <= ch ? ST_DONE : ST_DLD;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            acc_l  <= '0;
            acc_r  <= '0;
            peak_l <= '0;
            peak_r <= '0;
            cnt    <= '0;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_l <= in_mag_l;
      mag_r <= in_mag_r;
    end
    if (state == ST_SQL || state == ST_SQR) begin
      prod <= mul_ext * mul_ext;
    end
    unique case (state)
      ST_DLD: begin
        num <= {{(SQW - SUM_W){1'b0}}, (ch ? acc_r : acc_l)};
        rem <= '0;
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        num <= {num[SQW-2:0], op_ge};
        rem <= op_ge ? op_diff[RW-1:0] : op_a[RW-1:0];
      end
      ST_SLD: begin
        rem  <= '0;
        root <= '0;
      end
      ST_SQRT: begin
        // digit-by-digit square root, one root bit per cycle
        num  <= {num[SQW-3:0], 2'b00};
        rem  <= op_ge ? op_diff[RW-1:0] : op_a[RW-1:0];
        root <= root_next;
        if (step == STEP_W'(ROOT_W - 1)) begin
          if (ch) begin
            rms_r <= root_next[S-1:0];
          end else begin
            rms_l <= root_next[S-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      result.window_end_index <= seen;
      result.rms_left         <= rms_l;
      result.rms_right        <= rms_r;
      result.peak_left        <= peak_l;
      result.peak_right       <= peak_r;
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted sample always goes straight to squaring
  a_accept_to_square: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SQL))
    else $error("accepted sample did not start squaring");

  // a result only appears out of the final sequencer state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside window close");

  // closing a window clears its accumulators
  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (cnt == '0 && acc_l == '0 && acc_r == '0 && peak_l == '0))
    else $error("window state not cleared after close");

  // partial remainder of the divider stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step != '0) |-> ({1'b0, rem} < {{(RW - W){1'b0}}, divisor}))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

/* rtl/windowed_rms_peak_meter.sv */
// Stereo windowed RMS and peak meter. Each accepted sample pair passes through
// magnitude, two squares on one shared multiplier, and accumulate before
// sample_ready returns. A sample that closes a window adds the bit-serial divide
// and square root for each channel on one shared subtract unit, over SQW bits,
// the even-rounded accumulator width (64 at WINDOW_BITS = 16). The result
// sits in an output register; the next sample is accepted while it waits, but
// the following window close holds until it is taken. window_length is written
// through the APB port at byte address 0.
`default_nettype none

module windowed_rms_peak_meter #(
  parameter int WINDOW_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wrpm_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  // sample channel
  input  wire logic                           sample_valid,
  output logic                                sample_ready,
  input  wire wrpm_pkg::sample_t              sample,
  // result channel
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output wrpm_pkg::result_t                   result
);

  localparam int CFG_W = (WINDOW_BITS < wrpm_pkg::CFG_FIELD_BITS) ? WINDOW_BITS
                                                                  : wrpm_pkg::CFG_FIELD_BITS;

  logic [CFG_W-1:0] win_len;
  logic             reg_hit;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2:2] == wrpm_pkg::REG_WINDOW_LENGTH);
  assign wr_en   = psel & penable & pwrite & pready & reg_hit;

  // window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= CFG_W'(wrpm_pkg::WINDOW_LENGTH_RESET);
    end else if (wr_en) begin
      win_len <= CFG_W'(pwdata[wrpm_pkg::CFG_FIELD_BITS-1:0]);
    end
  end

  // register read
  assign prdata = reg_hit ? {{(32 - CFG_W){1'b0}}, win_len} : 32'd0;

  wrpm_core #(
    .WINDOW_BITS (WINDOW_BITS),
    .CFG_W       (CFG_W)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .win_len      (win_len),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
